// File: hw/rtl/i2cms_pkg.sv
// I2C master transfer sequencer: shared types, event and command codes.
// No dependencies; used by every file in hw/rtl.
`timescale 1ns / 1ps

package i2cms_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam logic [7:0] READ_BIT = 8'h01;

	typedef enum logic [2:0] {
		KIND_START_WR   = 3'd0,
		KIND_START_RD   = 3'd1,
		KIND_START_SENT = 3'd2,
		KIND_ADDR_ACK   = 3'd3,
		KIND_RX_READY   = 3'd4,
		KIND_TX_EMPTY   = 3'd5,
		KIND_ERROR      = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_START_ACK = 3'd1,
		CMD_STOP_ON   = 3'd2,
		CMD_STOP      = 3'd3,
		CMD_CLEAR     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		CMP_NONE = 2'd0,
		CMP_OK   = 2'd1,
		CMP_FAIL = 2'd2
	} cmp_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] length;
		logic        transmitter;
		logic [7:0]  rx_data;
		logic [7:0]  tx_data;
		logic        ack_failure;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic        dr_write_valid;
		logic [7:0]  dr_write_data;
		logic        cr1_write_valid;
		logic [2:0]  cr1_command;
		logic        rx_valid;
		logic [7:0]  rx_byte;
		logic [15:0] byte_index;
		logic        tx_consumed;
		logic [1:0]  completion;
	} result_t;

endpackage

// File: hw/rtl/i2cms_core.sv
// Transfer state (busy, direction, count, position, address) and the per-event decision.
// Depends on i2cms_pkg.
`timescale 1ns / 1ps

module i2cms_core #(
	parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [7:0]          cfg_wdata,
	input  logic                step,
	input  i2cms_pkg::item_t    item,
	output i2cms_pkg::result_t  result
);

	logic                   busy_q, busy_n;
	logic                   reading_q, reading_n;
	logic [COUNT_WIDTH-1:0] remaining_q, remaining_n;
	logic [COUNT_WIDTH-1:0] position_q, position_n;
	logic [7:0]             dev_addr_q;

	logic [COUNT_WIDTH+15:0] len_ext;
	logic [COUNT_WIDTH+15:0] pos_ext;
	logic [COUNT_WIDTH-1:0]  rem_dec;
	logic [COUNT_WIDTH-1:0]  pos_inc;

	assign len_ext = {{COUNT_WIDTH{1'b0}}, item.length};
	assign pos_ext = {16'b0, position_q};
	assign rem_dec = remaining_q - COUNT_WIDTH'(1);
	assign pos_inc = position_q + COUNT_WIDTH'(1);

	always_comb begin
		result      = '0;
		busy_n      = busy_q;
		reading_n   = reading_q;
		remaining_n = remaining_q;
		position_n  = position_q;
		unique case (item.kind)
			i2cms_pkg::KIND_START_WR, i2cms_pkg::KIND_START_RD: begin
				if (!busy_q && item.length != 16'd0) begin
					busy_n                 = 1'b1;
					reading_n              = (item.kind == i2cms_pkg::KIND_START_RD);
					remaining_n            = len_ext[COUNT_WIDTH-1:0];
					position_n             = '0;
					result.accepted        = 1'b1;
					result.cr1_write_valid = 1'b1;
					result.cr1_command     = (reading_n && item.length != 16'd1) ?
						i2cms_pkg::CMD_START_ACK : i2cms_pkg::CMD_START;
				end
			end
			i2cms_pkg::KIND_START_SENT: begin
				if (busy_q) begin
					result.dr_write_valid = 1'b1;
					result.dr_write_data  = dev_addr_q | (reading_q ? i2cms_pkg::READ_BIT : 8'h00);
				end
			end
			i2cms_pkg::KIND_ADDR_ACK: begin
				if (busy_q) begin
					if (item.transmitter) begin
						if (remaining_q != '0) begin
							result.dr_write_valid = 1'b1;
							result.dr_write_data  = item.tx_data;
							result.byte_index     = pos_ext[15:0];
							result.tx_consumed    = 1'b1;
							position_n            = pos_inc;
							remaining_n           = rem_dec;
							if (rem_dec == '0) begin
								result.cr1_write_valid = 1'b1;
								result.cr1_command     = i2cms_pkg::CMD_STOP_ON;
							end
						end
					end else if (remaining_q == COUNT_WIDTH'(1)) begin
						result.cr1_write_valid = 1'b1;
						result.cr1_command     = i2cms_pkg::CMD_STOP_ON;
					end
				end
			end
			i2cms_pkg::KIND_RX_READY: begin
				if (busy_q && remaining_q != '0) begin
					result.rx_valid   = 1'b1;
					result.rx_byte    = item.rx_data;
					result.byte_index = pos_ext[15:0];
					position_n        = pos_inc;
					remaining_n       = rem_dec;
					if (rem_dec == COUNT_WIDTH'(1)) begin
						result.cr1_write_valid = 1'b1;
						result.cr1_command     = i2cms_pkg::CMD_STOP_ON;
					end else if (rem_dec == '0) begin
						result.cr1_write_valid = 1'b1;
						result.cr1_command     = i2cms_pkg::CMD_STOP;
						result.completion      = i2cms_pkg::CMP_OK;
						busy_n                 = 1'b0;
					end
				end
			end
			i2cms_pkg::KIND_TX_EMPTY: begin
				if (busy_q) begin
					if (remaining_q != '0) begin
						remaining_n           = rem_dec;
						result.dr_write_valid = 1'b1;
						result.dr_write_data  = item.tx_data;
						result.byte_index     = pos_ext[15:0];
						result.tx_consumed    = 1'b1;
						position_n            = pos_inc;
					end else begin
						result.cr1_write_valid = 1'b1;
						result.cr1_command     = i2cms_pkg::CMD_STOP;
						result.completion      = i2cms_pkg::CMP_OK;
						busy_n                 = 1'b0;
					end
				end
			end
			i2cms_pkg::KIND_ERROR: begin
				result.cr1_write_valid = 1'b1;
				result.cr1_command     = item.ack_failure ?
					i2cms_pkg::CMD_STOP : i2cms_pkg::CMD_CLEAR;
				if (busy_q) begin
					result.completion = i2cms_pkg::CMP_FAIL;
					busy_n            = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			reading_q   <= 1'b0;
			remaining_q <= '0;
			position_q  <= '0;
			dev_addr_q  <= 8'h00;
		end else begin
			if (cfg_wen) begin
				dev_addr_q <= cfg_wdata;
			end
			if (step) begin
				busy_q      <= busy_n;
				reading_q   <= reading_n;
				remaining_q <= remaining_n;
				position_q  <= position_n;
			end
		end
	end

endmodule

// File: hw/rtl/i2c_master_transfer_sequencer_unit.sv
// I2C master transfer sequencer top level: input register, decision core, result register.
// Depends on i2cms_pkg and i2cms_core.
// Path: a beat goes from the input register through the core into the result register.
// Throughput: one beat per cycle while unstalled; one registered pass through i2cms_core.
// Reset (arst_n low, asynchronous): idle, both stages empty, counters and address cleared.
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_unit #(
	parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [15:0] length,
	input  logic        transmitter,
	input  logic [7:0]  rx_data,
	input  logic [7:0]  tx_data,
	input  logic        ack_failure,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic        dr_write_valid,
	output logic [7:0]  dr_write_data,
	output logic        cr1_write_valid,
	output logic [2:0]  cr1_command,
	output logic        rx_valid,
	output logic [7:0]  rx_byte,
	output logic [15:0] byte_index,
	output logic        tx_consumed,
	output logic [1:0]  completion
);

	logic                valid_s1;
	i2cms_pkg::item_t    item_s1;
	logic                valid_s2;
	i2cms_pkg::result_t  result_s2;
	i2cms_pkg::result_t  result_c;
	logic                s2_free;
	logic                step;
	logic                in_take;

	assign s2_free  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_take  = in_valid && !in_stall;

	i2cms_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.step     (step),
		.item     (item_s1),
		.result   (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{kind: kind, length: length, transmitter: transmitter,
				rx_data: rx_data, tx_data: tx_data, ack_failure: ack_failure};
		end
		if (step) begin
			result_s2 <= result_c;
		end
	end

	assign out_valid       = valid_s2;
	assign accepted        = result_s2.accepted;
	assign dr_write_valid  = result_s2.dr_write_valid;
	assign dr_write_data   = result_s2.dr_write_data;
	assign cr1_write_valid = result_s2.cr1_write_valid;
	assign cr1_command     = result_s2.cr1_command;
	assign rx_valid        = result_s2.rx_valid;
	assign rx_byte         = result_s2.rx_byte;
	assign byte_index      = result_s2.byte_index;
	assign tx_consumed     = result_s2.tx_consumed;
	assign completion      = result_s2.completion;

endmodule

// File: hw/rtl/i2cms_checker.sv
// Port-level checker for the I2C master transfer sequencer, bound to the top level.
// Depends on i2cms_pkg.
`timescale 1ns / 1ps

module i2cms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        accepted,
	input logic        dr_write_valid,
	input logic [7:0]  dr_write_data,
	input logic        cr1_write_valid,
	input logic [2:0]  cr1_command,
	input logic        rx_valid,
	input logic        tx_consumed,
	input logic [1:0]  completion
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dr_write_data)
			&& $stable(cr1_command) && $stable(completion))
		else $error("stalled result beat changed");

	a_start_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> cr1_write_valid
			&& (cr1_command == i2cms_pkg::CMD_START || cr1_command == i2cms_pkg::CMD_START_ACK)
			&& completion == i2cms_pkg::CMP_NONE)
		else $error("accepted start without start command");

	a_done_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && completion != i2cms_pkg::CMP_NONE |-> cr1_write_valid && !accepted)
		else $error("completion without control write");

	a_tx_dr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_consumed |-> dr_write_valid && !rx_valid)
		else $error("tx byte consumed without data register write");

	a_rx_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid |-> !dr_write_valid && !accepted)
		else $error("receive beat also writes data register");

endmodule

bind i2c_master_transfer_sequencer_unit i2cms_checker u_i2cms_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.accepted       (accepted),
	.dr_write_valid (dr_write_valid),
	.dr_write_data  (dr_write_data),
	.cr1_write_valid(cr1_write_valid),
	.cr1_command    (cr1_command),
	.rx_valid       (rx_valid),
	.tx_consumed    (tx_consumed),
	.completion     (completion)
);
